// ===== hdl/tccc_pkg.sv =====
// Shared types and constants for the text console cursor controller.
// No dependencies; used by tccc_ctrl, tccc_dpath and the top level.
package tccc_pkg;

    // result action codes
    typedef enum logic [1:0] {
        ACT_DRAW   = 2'd0,
        ACT_SCROLL = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    // configuration register indexes
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_FG      = 2'd2;
    localparam logic [1:0] CFG_BG      = 2'd3;

    localparam logic [7:0]  RST_COLUMNS = 8'd80;
    localparam logic [6:0]  RST_ROWS    = 7'd30;
    localparam logic [23:0] RST_FG      = 24'hFFFFFF;
    localparam logic [23:0] RST_BG      = 24'h000000;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [8:0] TAB_STEP = 9'd4;
    localparam logic [8:0] TAB_MASK = 9'h1FC;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOOP,
        S_NL
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take;         // input channel ready
        logic init_loop;    // set up working column, stop and glyph
        logic emit_draw;    // draw at working column, advance it
        logic emit_bs;      // step cursor back and blank that cell
        logic emit_scroll;  // scroll beat
        logic emit_clear;   // clear beat, cursor home
        logic col_zero;     // carriage return
        logic set_col;      // cursor column from working column
        logic newline;      // cursor to start of next line
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_clear;
        logic is_nl;
        logic is_cr;
        logic is_bs;
        logic is_prt;       // printable byte or tab
        logic bs_ok;
        logic draw_more;
        logic wrap;
        logic scroll;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/text_console_cursor_control.sv =====
// Text console cursor controller, top level over tccc_ctrl and tccc_dpath; uses tccc_pkg.
// The input byte is registered and decoded in S_EXEC; a line feed then goes through S_NL,
//   a printable byte or tab through the S_LOOP draws, then S_NL on wrap.
// Result beats are registered. A new byte is taken only back in S_IDLE, once the last is done;
//   stalls on the result port hold the sequence.
// Reset (synchronous, active low): cursor home, registers to 80x30, white on black.
module text_console_cursor_control (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // char_code[7:0]
    input  logic        i_s_tuser,   // mode[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // cell_col[7:0], cell_row[14:8], glyph[22:15], fore[46:23], back[70:47],
    // zero fill [71]
    output logic [71:0] o_m_tdata,
    output logic [1:0]  o_m_tuser,   // action[1:0]
    output logic        o_m_tlast    // last
);

    tccc_pkg::t_cmd    w_cmd;
    tccc_pkg::t_status w_st;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = w_cmd.take;

    tccc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    tccc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (w_cmd),
        .o_st        (w_st)
    );

endmodule

// ===== hdl/tccc_ctrl.sv =====
// Sequencer for the cursor controller: walks one input item through decode,
// draw loop and line feed. Depends on tccc_pkg.
module tccc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  tccc_pkg::t_status i_st,
    output tccc_pkg::t_cmd   o_cmd
);

    tccc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tccc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tccc_pkg::S_IDLE: begin
                if (i_s_tvalid) n_state = tccc_pkg::S_EXEC;
            end
            tccc_pkg::S_EXEC: begin
                priority if (i_st.is_clear) begin
                    if (i_st.out_free) n_state = tccc_pkg::S_IDLE;
                end else if (i_st.is_nl) begin
                    n_state = tccc_pkg::S_NL;
                end else if (i_st.is_bs) begin
                    if (!i_st.bs_ok || i_st.out_free) n_state = tccc_pkg::S_IDLE;
                end else if (i_st.is_prt) begin
                    n_state = tccc_pkg::S_LOOP;
                end else begin
                    n_state = tccc_pkg::S_IDLE;
                end
            end
            tccc_pkg::S_LOOP: begin
                if (!i_st.draw_more) begin
                    n_state = i_st.wrap ? tccc_pkg::S_NL : tccc_pkg::S_IDLE;
                end
            end
            tccc_pkg::S_NL: begin
                if (!i_st.scroll || i_st.out_free) n_state = tccc_pkg::S_IDLE;
            end
            default: n_state = tccc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            tccc_pkg::S_IDLE: begin
                o_cmd.take = 1'b1;
            end
            tccc_pkg::S_EXEC: begin
                priority if (i_st.is_clear) begin
                    o_cmd.emit_clear = i_st.out_free;
                end else if (i_st.is_nl) begin
                    o_cmd = '0;
                end else if (i_st.is_cr) begin
                    o_cmd.col_zero = 1'b1;
                end else if (i_st.is_bs) begin
                    o_cmd.emit_bs = i_st.bs_ok && i_st.out_free;
                end else if (i_st.is_prt) begin
                    o_cmd.init_loop = 1'b1;
                end else begin
                    o_cmd = '0;
                end
            end
            tccc_pkg::S_LOOP: begin
                if (i_st.draw_more) begin
                    o_cmd.emit_draw = i_st.out_free;
                end else if (!i_st.wrap) begin
                    o_cmd.set_col = 1'b1;
                end
            end
            tccc_pkg::S_NL: begin
                if (i_st.scroll) begin
                    o_cmd.emit_scroll = i_st.out_free;
                    o_cmd.newline     = i_st.out_free;
                end else begin
                    o_cmd.newline = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hdl/tccc_dpath.sv =====
// Datapath of the cursor controller: config registers, cursor, draw loop
// registers and the output register. Depends on tccc_pkg.
module tccc_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [23:0]       i_cfg_data,
    input  logic              i_s_tvalid,
    input  logic              i_s_tuser,
    input  logic [7:0]        i_s_tdata,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic              o_m_tlast,
    output logic [1:0]        o_m_tuser,
    output logic [71:0]       o_m_tdata,
    input  tccc_pkg::t_cmd    i_cmd,
    output tccc_pkg::t_status o_st
);

    logic [7:0]  r_cols;
    logic [6:0]  r_rows;
    logic [23:0] r_fg, r_bg;
    logic [7:0]  r_col;
    logic [6:0]  r_row;
    logic        r_mode;
    logic [7:0]  r_ch;
    logic [8:0]  r_wcol, r_stop;
    logic [7:0]  r_glyph;

    logic        r_out_valid;
    tccc_pkg::t_action r_act;
    logic [7:0]  r_ocol, r_oglyph;
    logic [6:0]  r_orow;
    logic [23:0] r_ofore, r_oback;
    logic        r_olast;

    logic        w_is_tab;
    logic [8:0]  w_tab_raw, w_tab_stop, w_cols9, w_wcol_inc;
    logic [7:0]  w_row_inc, w_rows8;
    logic [6:0]  w_row_next;
    logic        w_draw_last;

    assign w_cols9    = {1'b0, r_cols};
    assign w_rows8    = {1'b0, r_rows};
    assign w_row_inc  = {1'b0, r_row} + 8'd1;
    assign w_wcol_inc = r_wcol + 9'd1;
    assign w_is_tab   = !r_mode && (r_ch == tccc_pkg::CH_TAB);
    assign w_tab_raw  = ({1'b0, r_col} + tccc_pkg::TAB_STEP) & tccc_pkg::TAB_MASK;
    assign w_tab_stop = (w_tab_raw > w_cols9) ? w_cols9 : w_tab_raw;

    always_comb begin
        o_st.is_clear  = r_mode;
        o_st.is_nl     = !r_mode && (r_ch == tccc_pkg::CH_NL);
        o_st.is_cr     = !r_mode && (r_ch == tccc_pkg::CH_CR);
        o_st.is_bs     = !r_mode && (r_ch == tccc_pkg::CH_BS);
        o_st.is_prt    = w_is_tab || (!r_mode && (r_ch >= tccc_pkg::CH_SPACE));
        o_st.bs_ok     = (r_col != 8'd0);
        o_st.draw_more = (r_wcol < r_stop);
        o_st.wrap      = (r_wcol >= w_cols9);
        o_st.scroll    = (w_row_inc >= w_rows8);
        o_st.out_free  = !r_out_valid || i_m_tready;
    end

    // a scroll pending after the loop makes the final draw not the last beat
    assign w_draw_last = (w_wcol_inc == r_stop) && !((r_stop >= w_cols9) && o_st.scroll);

    always_comb begin
        if (!o_st.scroll) begin
            w_row_next = w_row_inc[6:0];
        end else if (r_rows != 7'd0) begin
            w_row_next = r_rows - 7'd1;
        end else begin
            w_row_next = 7'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= tccc_pkg::RST_COLUMNS;
            r_rows <= tccc_pkg::RST_ROWS;
            r_fg   <= tccc_pkg::RST_FG;
            r_bg   <= tccc_pkg::RST_BG;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tccc_pkg::CFG_COLUMNS: r_cols <= i_cfg_data[7:0];
                tccc_pkg::CFG_ROWS:    r_rows <= i_cfg_data[6:0];
                tccc_pkg::CFG_FG:      r_fg   <= i_cfg_data;
                tccc_pkg::CFG_BG:      r_bg   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 8'd0;
            r_row <= 7'd0;
        end else begin
            if (i_cmd.emit_clear) begin
                r_col <= 8'd0;
                r_row <= 7'd0;
            end else if (i_cmd.newline) begin
                r_col <= 8'd0;
                r_row <= w_row_next;
            end else if (i_cmd.col_zero) begin
                r_col <= 8'd0;
            end else if (i_cmd.emit_bs) begin
                r_col <= r_col - 8'd1;
            end else if (i_cmd.set_col) begin
                r_col <= r_wcol[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_s_tvalid) begin
            r_mode <= i_s_tuser;
            r_ch   <= i_s_tdata;
        end
        if (i_cmd.init_loop) begin
            r_wcol  <= {1'b0, r_col};
            r_stop  <= w_is_tab ? w_tab_stop : ({1'b0, r_col} + 9'd1);
            r_glyph <= w_is_tab ? tccc_pkg::CH_SPACE : r_ch;
        end else if (i_cmd.emit_draw) begin
            r_wcol <= w_wcol_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_draw || i_cmd.emit_bs || i_cmd.emit_scroll
                     || i_cmd.emit_clear) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_draw) begin
            r_act    <= tccc_pkg::ACT_DRAW;
            r_ocol   <= r_wcol[7:0];
            r_orow   <= r_row;
            r_oglyph <= r_glyph;
            r_ofore  <= r_fg;
            r_oback  <= r_bg;
            r_olast  <= w_draw_last;
        end else if (i_cmd.emit_bs) begin
            r_act    <= tccc_pkg::ACT_DRAW;
            r_ocol   <= r_col - 8'd1;
            r_orow   <= r_row;
            r_oglyph <= tccc_pkg::CH_SPACE;
            r_ofore  <= r_fg;
            r_oback  <= r_bg;
            r_olast  <= 1'b1;
        end else if (i_cmd.emit_scroll) begin
            r_act    <= tccc_pkg::ACT_SCROLL;
            r_ocol   <= 8'd0;
            r_orow   <= 7'd0;
            r_oglyph <= 8'd0;
            r_ofore  <= 24'd0;
            r_oback  <= 24'd0;
            r_olast  <= 1'b1;
        end else if (i_cmd.emit_clear) begin
            r_act    <= tccc_pkg::ACT_CLEAR;
            r_ocol   <= 8'd0;
            r_orow   <= 7'd0;
            r_oglyph <= 8'd0;
            r_ofore  <= 24'd0;
            r_oback  <= r_bg;
            r_olast  <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_act;
    assign o_m_tdata  = {1'b0, r_oback, r_ofore, r_oglyph, r_orow, r_ocol};

    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.emit_draw, i_cmd.emit_bs, i_cmd.emit_scroll, i_cmd.emit_clear}))
        else $error("more than one result beat loaded at once");

    a_draw_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_draw |-> (r_wcol < r_stop))
        else $error("draw past the loop stop");

    a_clear_homes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_clear |=> (r_col == 8'd0) && (r_row == 7'd0))
        else $error("cursor not home after clear");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_draw || i_cmd.emit_bs || i_cmd.emit_scroll || i_cmd.emit_clear)
        |-> (!r_out_valid || i_m_tready))
        else $error("result beat overwritten before it was taken");

endmodule
